FILE: hdl/rgb_pixel_point_operations_defines.svh
// Assertion helpers shared by the RTL files.
`ifndef RGB_PIXEL_POINT_OPERATIONS_DEFINES_SVH
`define RGB_PIXEL_POINT_OPERATIONS_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RPO_ASSERT_IMP(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |-> (cons)) else $error("rpo implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define RPO_ASSERT_NXT(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |=> (cons)) else $error("rpo next-cycle check failed");

`endif

FILE: hdl/rpo_pkg.sv
`default_nettype none

package rpo_pkg;

    localparam int CH_W    = 8;
    localparam int DELTA_W = 9;
    localparam int GAIN_W  = 16;
    localparam int IDX_W   = 2;
    localparam int LUMA_W  = 18;
    localparam int PROD_W  = CH_W + GAIN_W;
    localparam int RECIP_W = 19;
    localparam int GRAY_SHIFT = 28;

    // Luma weights; the sum is divided by 1000 through a reciprocal multiply.
    localparam logic [LUMA_W-1:0] W_RED   = 18'd299;
    localparam logic [LUMA_W-1:0] W_GREEN = 18'd587;
    localparam logic [LUMA_W-1:0] W_BLUE  = 18'd114;
    // ceil(2^28 / 1000); exact for every sum up to 255 * 1000.
    localparam logic [RECIP_W-1:0] GRAY_RECIP = 19'd268436;

    localparam logic signed [GAIN_W-1:0]  GAIN_UNITY = 16'sd256;
    localparam logic signed [DELTA_W-1:0] DELTA_ZERO = 9'sd0;

    typedef enum logic [1:0] {
        MODE_GRAY     = 2'd0,
        MODE_INVERT   = 2'd1,
        MODE_BRIGHT   = 2'd2,
        MODE_CONTRAST = 2'd3
    } op_mode_t;

    localparam logic [IDX_W-1:0] REG_OP_MODE = 2'd0;
    localparam logic [IDX_W-1:0] REG_DELTA   = 2'd1;
    localparam logic [IDX_W-1:0] REG_GAIN    = 2'd2;

    typedef struct packed {
        op_mode_t                   mode;
        logic signed [DELTA_W-1:0]  delta;
        logic signed [GAIN_W-1:0]   gain;
    } cfg_t;

    typedef struct packed {
        logic              frame_end;
        logic [CH_W-1:0]   blue;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   red;
    } pix_t;

    // Intermediate values of one pixel between the product and finish stages.
    typedef struct packed {
        op_mode_t                 mode;
        logic                     frame_end;
        logic [LUMA_W-1:0]        luma_sum;
        logic [2:0][PROD_W-1:0]   con_prod;
        logic [2:0][CH_W-1:0]     direct;
    } prod_t;

    function automatic logic [CH_W-1:0] clamp_bright(input logic signed [CH_W+1:0] v);
        logic [CH_W-1:0] res;
        if (v < 0)
        begin
            res = '0;
        end
        else if (v > 10'sd255)
        begin
            res = '1;
        end
        else
        begin
            res = v[CH_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [CH_W-1:0] clamp_con(input logic signed [GAIN_W:0] v);
        logic [CH_W-1:0] res;
        if (v < 0)
        begin
            res = '0;
        end
        else if (v > 17'sd255)
        begin
            res = '1;
        end
        else
        begin
            res = v[CH_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/rgb_pixel_point_operations.sv
// An accepted input beat moves through the input, product and output registers before its
// result beat appears on the master side.
// Throughput: one pixel per clock while m_tready is high; the pipeline collapses bubbles, so a
// stall only backs up stages that hold data. The multiplies sit in the product and finish stages.
// Reset clears all stage valid flags and sets op_mode to grayscale, delta 0, gain 1.0.
`default_nettype none
`include "rgb_pixel_point_operations_defines.svh"

module rgb_pixel_point_operations
    import rpo_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [23:0]       s_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
    input  wire logic              s_tlast,   // frame_end_in
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [23:0]            m_tdata,   // red_out [7:0], green_out [15:8], blue_out [23:16]
    output logic                   m_tlast,   // frame_end_out
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [GAIN_W-1:0] cfg_data
);

    cfg_t  cfg;
    logic  in_valid_reg;
    logic  in_valid_next;
    pix_t  in_pix_reg;
    pix_t  in_pix_next;
    logic  prod_ready;
    logic  prod_valid;
    prod_t prod;
    logic  fin_ready;
    pix_t  out_pix;

    rpo_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign s_tready = !in_valid_reg || prod_ready;

    always_comb
    begin
        in_pix_next.red       = s_tdata[7:0];
        in_pix_next.green     = s_tdata[15:8];
        in_pix_next.blue      = s_tdata[23:16];
        in_pix_next.frame_end = s_tlast;
        in_valid_next         = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_pix_reg <= in_pix_next;
        end
    end

    rpo_product u_product (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid_reg),
        .in_ready  (prod_ready),
        .pix       (in_pix_reg),
        .out_valid (prod_valid),
        .out_ready (fin_ready),
        .prod      (prod)
    );

    rpo_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_ready  (fin_ready),
        .prod      (prod),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .pix       (out_pix)
    );

    assign m_tdata = {out_pix.blue, out_pix.green, out_pix.red};
    assign m_tlast = out_pix.frame_end;

    // A sink that is ready lets every stage move, so the slave side is open too.
    `RPO_ASSERT_IMP(a_ready_chain, clk, rst_n, m_tready, s_tready)
    // A beat held in the input register while the product stage is open moves on.
    `RPO_ASSERT_NXT(a_in_moves, clk, rst_n, in_valid_reg && prod_ready && !s_tvalid,
        !in_valid_reg)

endmodule

`default_nettype wire

FILE: hdl/rpo_cfg_regs.sv
`default_nettype none

module rpo_cfg_regs
    import rpo_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [GAIN_W-1:0] cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_OP_MODE: cfg_next.mode  = op_mode_t'(cfg_data[1:0]);
                REG_DELTA:   cfg_next.delta = $signed(cfg_data[DELTA_W-1:0]);
                REG_GAIN:    cfg_next.gain  = $signed(cfg_data);
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode  <= MODE_GRAY;
            cfg_reg.delta <= DELTA_ZERO;
            cfg_reg.gain  <= GAIN_UNITY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rpo_product.sv
`default_nettype none
`include "rgb_pixel_point_operations_defines.svh"

module rpo_product
    import rpo_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire pix_t  pix,
    output logic       out_valid,
    input  wire logic  out_ready,
    output prod_t      prod
);

    logic  valid_reg;
    logic  valid_next;
    prod_t prod_reg;
    prod_t prod_next;
    logic  advance;

    logic [2:0][CH_W-1:0] chan;

    assign chan     = {pix.blue, pix.green, pix.red};
    assign in_ready = !valid_reg || out_ready;
    assign advance  = in_valid && in_ready;

    always_comb
    begin
        logic signed [CH_W-1:0]   diff;
        logic signed [PROD_W-1:0] p;
        logic signed [CH_W+1:0]   bsum;
        prod_next           = prod_reg;
        prod_next.mode      = cfg.mode;
        prod_next.frame_end = pix.frame_end;
        prod_next.luma_sum  = LUMA_W'(pix.red) * W_RED
                            + LUMA_W'(pix.green) * W_GREEN
                            + LUMA_W'(pix.blue) * W_BLUE;
        for (int i = 0; i < 3; i++)
        begin
            // c - 128 is the channel with its top bit flipped, read as signed.
            diff = $signed({~chan[i][CH_W-1], chan[i][CH_W-2:0]});
            p    = diff * cfg.gain;
            prod_next.con_prod[i] = p;
            bsum = $signed({2'b00, chan[i]}) + $signed({cfg.delta[DELTA_W-1], cfg.delta});
            if (cfg.mode == MODE_BRIGHT)
            begin
                prod_next.direct[i] = clamp_bright(bsum);
            end
            else
            begin
                prod_next.direct[i] = ~chan[i];
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg <= prod_next;
        end
    end

    assign out_valid = valid_reg;
    assign prod      = prod_reg;

    `RPO_ASSERT_NXT(a_prod_fill, clk, rst_n, advance, valid_reg)

endmodule

`default_nettype wire

FILE: hdl/rpo_finish.sv
`default_nettype none
`include "rgb_pixel_point_operations_defines.svh"

module rpo_finish
    import rpo_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire prod_t prod,
    output logic       out_valid,
    input  wire logic  out_ready,
    output pix_t       pix
);

    logic     valid_reg;
    logic     valid_next;
    pix_t     pix_reg;
    pix_t     pix_next;
    op_mode_t mode_reg;
    logic     advance;

    logic [LUMA_W+RECIP_W-1:0] gray_prod;
    logic [CH_W-1:0]           gray;
    logic [2:0][CH_W-1:0]      res;

    assign in_ready  = !valid_reg || out_ready;
    assign advance   = in_valid && in_ready;
    assign gray_prod = (LUMA_W+RECIP_W)'(prod.luma_sum) * (LUMA_W+RECIP_W)'(GRAY_RECIP);
    assign gray      = gray_prod[GRAY_SHIFT+CH_W-1:GRAY_SHIFT];

    always_comb
    begin
        logic signed [GAIN_W:0] shifted;
        for (int i = 0; i < 3; i++)
        begin
            // Arithmetic shift by 8 floors the Q16.8 product toward minus infinity.
            shifted = $signed({prod.con_prod[i][PROD_W-1], prod.con_prod[i][PROD_W-1:CH_W]})
                    + 17'sd128;
            case (prod.mode)
                MODE_GRAY:     res[i] = gray;
                MODE_CONTRAST: res[i] = clamp_con(shifted);
                default:       res[i] = prod.direct[i];
            endcase
        end
        pix_next.red       = res[0];
        pix_next.green     = res[1];
        pix_next.blue      = res[2];
        pix_next.frame_end = prod.frame_end;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pix_reg  <= pix_next;
            mode_reg <= prod.mode;
        end
    end

    assign out_valid = valid_reg;
    assign pix       = pix_reg;

    `RPO_ASSERT_IMP(a_gray_equal, clk, rst_n, valid_reg && (mode_reg == MODE_GRAY),
        (pix_reg.red == pix_reg.green) && (pix_reg.green == pix_reg.blue))

endmodule

`default_nettype wire
